@@ sv/bct_pkg.sv @@
// Shared types, hash constants and command codes for the change tracker.
package bct_pkg;

   localparam int FILTER_BITS = 16;
   localparam int FILTER_IDX_W = 4;
   localparam int HASH_IDX_W = 3;

   localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MUR_C2 = 32'h1b873593;
   localparam logic [31:0] MUR_MIX_ADD = 32'he6546b64;
   localparam logic [31:0] MUR_FMIX1 = 32'h85ebca6b;
   localparam logic [31:0] MUR_FMIX2 = 32'hc2b2ae35;

   typedef logic [FILTER_BITS-1:0] filter_type;

   typedef enum logic [2:0] {
      KIND_MARK_CHANGED = 3'd0,
      KIND_MARK_GLOBAL  = 3'd1,
      KIND_QUERY        = 3'd2,
      KIND_POP          = 3'd3,
      KIND_REMARK       = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] key_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        had_changes;
      logic        notify;
      logic [15:0] tick_bits;
      logic [15:0] global_bits;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCR1_BODY,
      OP_SCR1_TAIL,
      OP_SCR2,
      OP_MIX,
      OP_FIN_LOAD,
      OP_FIN_A,
      OP_FIN_B,
      OP_APPLY
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCR_A,
      ST_SCR_B,
      ST_BODY,
      ST_FINISH,
      ST_TAIL_A,
      ST_TAIL_B,
      ST_FIN_LOAD,
      ST_FIN_A,
      ST_FIN_B,
      ST_APPLY
   } state_type;

   typedef struct packed {
      op_type                op;
      logic [2:0]            kind;
      logic [HASH_IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0] pos;
   } status_type;

endpackage

@@ sv/bct_ctrl.sv @@
// Sequencing state machine for the change tracker: item decode and hash steps.
module bct_ctrl import bct_pkg::*; #(
   parameter int SEED_COUNT = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int IDX_W = (SEED_COUNT > 1) ? $clog2(SEED_COUNT) : 1;

   state_type        state_ff, state_in;
   logic             in_key_ff, in_key_in;
   logic [2:0]       kind_ff, kind_in;
   logic             last_ff, last_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic accept, is_filter_op, is_unused, start_filter, key_item, do_load, do_body;
   logic idx_last, slot_free, apply_fire;

   assign accept       = req_valid && (state_ff == ST_IDLE);
   assign is_filter_op = (req_payload.kind == 3'(KIND_POP)) ||
                         (req_payload.kind == 3'(KIND_REMARK));
   assign is_unused    = req_payload.kind > 3'(KIND_REMARK);
   assign start_filter = !in_key_ff && is_filter_op;
   assign key_item     = in_key_ff || !(is_filter_op || is_unused);
   assign do_load      = key_item && req_payload.byte_present;
   assign do_body      = do_load && (status.pos == 2'd3);
   assign idx_last     = (idx_ff == IDX_W'(SEED_COUNT - 1));
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign apply_fire   = (state_ff == ST_APPLY) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (start_filter) begin
                  state_in = ST_APPLY;
               end else if (key_item) begin
                  if (do_body) begin
                     state_in = ST_SCR_A;
                  end else if (req_payload.last_byte) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_SCR_A:  state_in = ST_SCR_B;
         ST_SCR_B:  state_in = ST_BODY;
         ST_BODY: begin
            if (idx_last) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: state_in = (status.pos != 2'd0) ? ST_TAIL_A : ST_FIN_LOAD;
         ST_TAIL_A: state_in = ST_TAIL_B;
         ST_TAIL_B: state_in = ST_FIN_LOAD;
         ST_FIN_LOAD: state_in = ST_FIN_A;
         ST_FIN_A:  state_in = ST_FIN_B;
         ST_FIN_B:  state_in = idx_last ? ST_APPLY : ST_FIN_LOAD;
         ST_APPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.kind = kind_ff;
      cmd.idx  = HASH_IDX_W'(idx_ff);
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE:     cmd.op = (accept && do_load) ? OP_LOAD : OP_NONE;
         ST_SCR_A:    cmd.op = OP_SCR1_BODY;
         ST_TAIL_A:   cmd.op = OP_SCR1_TAIL;
         ST_SCR_B:    cmd.op = OP_SCR2;
         ST_TAIL_B:   cmd.op = OP_SCR2;
         ST_BODY:     cmd.op = OP_MIX;
         ST_FIN_LOAD: cmd.op = OP_FIN_LOAD;
         ST_FIN_A:    cmd.op = OP_FIN_A;
         ST_FIN_B:    cmd.op = OP_FIN_B;
         ST_APPLY:    cmd.op = slot_free ? OP_APPLY : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      in_key_in    = in_key_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept && !in_key_ff) begin
         kind_in = req_payload.kind;
         if (key_item) begin
            in_key_in = 1'b1;
         end
      end
      if (accept && key_item) begin
         last_in = req_payload.last_byte;
      end
      if ((state_ff == ST_BODY) || (state_ff == ST_FIN_B)) begin
         idx_in = idx_last ? '0 : idx_ff + 1'b1;
      end
      if (apply_fire) begin
         in_key_in    = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_key_ff    <= 1'b0;
         kind_ff      <= '0;
         last_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         kind_ff      <= kind_in;
         last_ff      <= last_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/bct_datapath.sv @@
// Hash datapath with one shared multiplier, both filters and the result register.
module bct_datapath import bct_pkg::*; #(
   parameter int SEED_COUNT = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_payload
);

   localparam int IDX_W = (SEED_COUNT > 1) ? $clog2(SEED_COUNT) : 1;

   logic [31:0] acc_ff [SEED_COUNT];
   logic [31:0] acc_in [SEED_COUNT];
   logic [23:0] partial_ff, partial_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] work_ff, work_in;
   logic [31:0] fin_ff, fin_in;
   filter_type  mask_ff, mask_in;
   filter_type  global_ff, global_in;
   filter_type  tick_ff, tick_in;
   rsp_type     rsp_ff, rsp_in;

   logic [IDX_W-1:0] idx;
   logic [31:0] mul_a, mul_b, prod;
   logic [31:0] acc_sel, mix_h, fin_x, fmix_t;
   logic [7:0]  b;
   logic        hit, had;

   assign idx     = cmd.idx[IDX_W-1:0];
   assign acc_sel = acc_ff[idx];
   assign b       = req_payload.key_byte;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SCR1_BODY: begin
            mul_a = work_ff;
            mul_b = MUR_C1;
         end
         OP_SCR1_TAIL: begin
            mul_a = {8'd0, partial_ff};
            mul_b = MUR_C1;
         end
         OP_SCR2: begin
            mul_a = {work_ff[16:0], work_ff[31:17]};
            mul_b = MUR_C2;
         end
         OP_FIN_A: begin
            mul_a = fin_ff;
            mul_b = MUR_FMIX1;
         end
         OP_FIN_B: begin
            mul_a = fin_ff;
            mul_b = MUR_FMIX2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign mix_h  = {acc_sel[18:0] ^ work_ff[18:0], acc_sel[31:19] ^ work_ff[31:19]};
   assign fin_x  = acc_sel ^ ((len_ff[1:0] != 2'd0) ? work_ff : 32'd0) ^ len_ff;
   assign fmix_t = prod ^ {16'd0, prod[31:16]};

   always_comb begin
      for (int i = 0; i < SEED_COUNT; i++) begin
         acc_in[i] = acc_ff[i];
      end
      partial_in = partial_ff;
      len_in     = len_ff;
      work_in    = work_ff;
      fin_in     = fin_ff;
      mask_in    = mask_ff;
      global_in  = global_ff;
      tick_in    = tick_ff;
      rsp_in     = rsp_ff;
      hit        = 1'b0;
      had        = 1'b0;
      unique case (cmd.op)
         OP_LOAD: begin
            len_in = len_ff + 32'd1;
            unique case (len_ff[1:0])
               2'd0: partial_in = {16'd0, b};
               2'd1: partial_in = {8'd0, b, partial_ff[7:0]};
               2'd2: partial_in = {b, partial_ff[15:0]};
               2'd3: begin
                  work_in    = {b, partial_ff};
                  partial_in = '0;
               end
               default: partial_in = partial_ff;
            endcase
         end
         OP_SCR1_BODY, OP_SCR1_TAIL: work_in = prod;
         OP_SCR2: work_in = prod;
         OP_MIX: acc_in[idx] = {mix_h[29:0], 2'b00} + mix_h + MUR_MIX_ADD;
         OP_FIN_LOAD: fin_in = fin_x ^ {16'd0, fin_x[31:16]};
         OP_FIN_A: fin_in = prod ^ {13'd0, prod[31:13]};
         OP_FIN_B: mask_in = mask_ff | (FILTER_BITS'(1) << fmix_t[FILTER_IDX_W-1:0]);
         OP_APPLY: begin
            case (cmd.kind)
               3'(KIND_MARK_CHANGED): begin
                  global_in = global_ff | mask_ff;
                  tick_in   = tick_ff | mask_ff;
               end
               3'(KIND_MARK_GLOBAL): global_in = global_ff | mask_ff;
               3'(KIND_QUERY): hit = ((tick_ff & mask_ff) == mask_ff);
               3'(KIND_POP): begin
                  had     = (tick_ff != '0);
                  tick_in = '0;
               end
               3'(KIND_REMARK): begin
                  had = (global_ff != '0);
                  if (had) begin
                     tick_in = global_ff;
                  end
               end
               default: had = 1'b0;
            endcase
            rsp_in.hit         = hit;
            rsp_in.had_changes = had;
            rsp_in.notify      = (cmd.kind == 3'(KIND_MARK_CHANGED));
            rsp_in.tick_bits   = 16'(tick_in);
            rsp_in.global_bits = 16'(global_in);
            for (int i = 0; i < SEED_COUNT; i++) begin
               acc_in[i] = 32'(i);
            end
            partial_in = '0;
            len_in     = '0;
            mask_in    = '0;
         end
         default: len_in = len_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEED_COUNT; i++) begin
            acc_ff[i] <= 32'(i);
         end
         partial_ff <= '0;
         len_ff     <= '0;
         mask_ff    <= '0;
         global_ff  <= '0;
         tick_ff    <= '0;
      end else begin
         for (int i = 0; i < SEED_COUNT; i++) begin
            acc_ff[i] <= acc_in[i];
         end
         partial_ff <= partial_in;
         len_ff     <= len_in;
         mask_ff    <= mask_in;
         global_ff  <= global_in;
         tick_ff    <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      fin_ff  <= fin_in;
      rsp_ff  <= rsp_in;
   end

   assign status.pos  = len_ff[1:0];
   assign rsp_payload = rsp_ff;

endmodule

@@ sv/bloom_change_tracker_murmur3.sv @@
// Top level of the changed-key tracker: two Bloom filters over MurmurHash3 x86_32.
// A byte that does not complete a four-byte block is only loaded; one that does is scrambled
// by two multiplies on the shared multiplier and mixed into each seed. The last item adds
// a tail scramble if one is pending, a finalize load and two fmix multiplies per seed, and
// apply; pop and remark only apply. Apply holds while an earlier result waits to be taken.
// Synchronous active-high reset clears both filters and restores the seeds; no clearing pass.
module bloom_change_tracker_murmur3 import bct_pkg::*; #(
   parameter int SEED_COUNT = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   bct_ctrl #(
      .SEED_COUNT(SEED_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   bct_datapath #(
      .SEED_COUNT(SEED_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .status     (status),
      .rsp_payload(rsp_payload)
   );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the Bloom-filter changed-key tracker over MurmurHash3 x86_32.
module tb_top;
   import bct_pkg::*;

   localparam int SEED_COUNT = 3;
   localparam int N_RANDOM = 650;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int POOL_KEYS = 6;
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_MID = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      req_type req;
      bit      fixed;
      bit      gives;
      rsp_type rsp;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   filter_type  glob_f;
   filter_type  tick_f;
   logic [31:0] seed_acc [SEED_COUNT];
   logic [31:0] tail_word;
   logic [31:0] key_len;
   logic [2:0]  key_kind;
   bit          key_open;

   rsp_type     due_q [$];
   plan_row_type plan [$];
   logic [7:0]  pool_bytes [POOL_KEYS][16];
   int          pool_len [POOL_KEYS];
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet = 0;
   int n_items = 0;
   int n_results = 0;
   int n_hits = 0;
   int n_notify = 0;
   int n_errors = 0;

   bloom_change_tracker_murmur3 #(
      .SEED_COUNT(SEED_COUNT)
   ) uut (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] mur_scramble(input logic [31:0] k);
      logic [31:0] t;
      t = k * MUR_C1;
      t = rotl(t, 15);
      return t * MUR_C2;
   endfunction

   function automatic void key_clear();
      for (int i = 0; i < SEED_COUNT; i++) seed_acc[i] = 32'(i);
      tail_word = '0;
      key_len = '0;
      key_kind = KIND_MARK_CHANGED;
      key_open = 1'b0;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      logic [31:0] k;
      logic [31:0] h;
      if (key_len[1:0] == 2'd3) begin
         k = mur_scramble(tail_word | {b, 24'h0});
         for (int i = 0; i < SEED_COUNT; i++) begin
            h = rotl(seed_acc[i] ^ k, 13);
            seed_acc[i] = h * 5 + MUR_MIX_ADD;
         end
         tail_word = '0;
      end else begin
         tail_word = tail_word | ({24'h0, b} << (8 * key_len[1:0]));
      end
      key_len = key_len + 1;
   endfunction

   function automatic filter_type key_mask();
      filter_type  m;
      logic [31:0] h;
      m = '0;
      for (int i = 0; i < SEED_COUNT; i++) begin
         h = seed_acc[i];
         if (key_len[1:0] != 2'd0) h = h ^ mur_scramble(tail_word);
         h = h ^ key_len;
         h = h ^ (h >> 16);
         h = h * MUR_FMIX1;
         h = h ^ (h >> 13);
         h = h * MUR_FMIX2;
         h = h ^ (h >> 16);
         m[h[3:0]] = 1'b1;
      end
      return m;
   endfunction

   function automatic void track_step(input req_type r, output bit made, output rsp_type o);
      filter_type m;
      made = 1'b0;
      o = '0;
      if (!key_open) begin
         if (r.kind == KIND_POP) begin
            o.had_changes = |tick_f;
            tick_f = '0;
            made = 1'b1;
         end else if (r.kind == KIND_REMARK) begin
            o.had_changes = |glob_f;
            if (|glob_f) tick_f = glob_f;
            made = 1'b1;
         end else if (r.kind <= KIND_QUERY) begin
            key_kind = r.kind;
            key_open = 1'b1;
         end
      end
      if (key_open) begin
         if (r.byte_present) absorb_byte(r.key_byte);
         if (r.last_byte) begin
            m = key_mask();
            case (key_kind)
               KIND_MARK_CHANGED: begin
                  glob_f = glob_f | m;
                  tick_f = tick_f | m;
                  o.notify = 1'b1;
               end
               KIND_MARK_GLOBAL: glob_f = glob_f | m;
               default: o.hit = ((tick_f & m) == m);
            endcase
            key_clear();
            made = 1'b1;
         end
      end
      if (made) begin
         o.tick_bits = tick_f;
         o.global_bits = glob_f;
      end
   endfunction

   function automatic plan_row_type mk_row(input logic [2:0] k, input logic [7:0] b,
                                           input logic p, input logic l,
                                           input bit fixed, input bit gives);
      plan_row_type row;
      row.req = '{kind: k, key_byte: b, byte_present: p, last_byte: l};
      row.fixed = fixed;
      row.gives = gives;
      row.rsp = '{hit: 1'b0, had_changes: 1'b0, notify: 1'b0, tick_bits: 16'h0,
                  global_bits: 16'h0};
      return row;
   endfunction

   function automatic void field_check(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   task automatic send_item(input req_type r, input bit fixed, input bit gives,
                            input rsp_type fixed_rsp);
      int      gap;
      bit      made;
      rsp_type got;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      track_step(r, made, got);
      if (fixed) begin
         made = gives;
         got = fixed_rsp;
      end
      if (made) due_q.push_back(got);
      n_items++;
   endtask

   task automatic send_random_op();
      req_type    r;
      logic [7:0] kb [16];
      int         roll;
      int         len;
      int         slot;
      roll = $urandom_range(99);
      r.kind = roll < 28 ? KIND_MARK_CHANGED : roll < 42 ? KIND_MARK_GLOBAL :
               roll < 72 ? KIND_QUERY : roll < 86 ? KIND_POP :
               roll < 95 ? KIND_REMARK : 3'($urandom_range(5, 7));
      r.key_byte = 8'($urandom);
      r.byte_present = 1'($urandom);
      r.last_byte = 1'($urandom);
      if (r.kind > KIND_QUERY) begin
         send_item(r, 1'b0, 1'b0, '0);
         return;
      end
      if ($urandom_range(1) == 1) begin
         slot = $urandom_range(POOL_KEYS - 1);
         len = pool_len[slot];
         for (int i = 0; i < len; i++) kb[i] = pool_bytes[slot][i];
      end else begin
         len = ($urandom_range(9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 7);
         for (int i = 0; i < len; i++) kb[i] = 8'($urandom);
      end
      if (len == 0) begin
         r.byte_present = 1'b0;
         r.last_byte = 1'b1;
         send_item(r, 1'b0, 1'b0, '0);
         return;
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            r.key_byte = 8'($urandom);
            r.byte_present = 1'b0;
            r.last_byte = 1'b0;
            send_item(r, 1'b0, 1'b0, '0);
            r.kind = 3'($urandom);
         end
         r.key_byte = kb[i];
         r.byte_present = 1'b1;
         r.last_byte = (i == len - 1);
         send_item(r, 1'b0, 1'b0, '0);
         r.kind = 3'($urandom);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want_r;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet);
         $display("tb_top: errors");
         $finish;
      end
      if (rsp_valid && rsp_ready) begin
         if (due_q.size() == 0) begin
            n_errors++;
            $display("%0t: result with nothing pending, expected none actual %p",
                     $time, rsp_payload);
         end else begin
            want_r = due_q.pop_front();
            n_results++;
            field_check("hit", 16'(want_r.hit), 16'(rsp_payload.hit));
            field_check("had_changes", 16'(want_r.had_changes), 16'(rsp_payload.had_changes));
            field_check("notify", 16'(want_r.notify), 16'(rsp_payload.notify));
            field_check("tick_bits", want_r.tick_bits, rsp_payload.tick_bits);
            field_check("global_bits", want_r.global_bits, rsp_payload.global_bits);
            if (rsp_payload.hit) n_hits++;
            if (rsp_payload.notify) n_notify++;
         end
      end
   end

   initial begin
      int n_directed;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      glob_f = '0;
      tick_f = '0;
      key_clear();
      for (int s = 0; s < POOL_KEYS; s++) begin
         pool_len[s] = (s == 0) ? 4 : (s == 1) ? 0 : $urandom_range(1, 9);
         for (int i = 0; i < 16; i++) pool_bytes[s][i] = 8'($urandom);
      end

      plan.push_back(mk_row(KIND_POP, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
      plan.push_back(mk_row(KIND_REMARK, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
      plan.push_back(mk_row(KIND_SPARE_LO, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
      plan.push_back(mk_row(KIND_SPARE_HI, 8'hff, 1'b1, 1'b1, 1'b1, 1'b0));
      plan.push_back(mk_row(KIND_SPARE_MID, 8'ha5, 1'b0, 1'b1, 1'b1, 1'b0));
      plan.push_back(mk_row(KIND_QUERY, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
      plan.push_back(mk_row(KIND_MARK_CHANGED, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_CHANGED, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_SPARE_HI, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_POP, 8'h63, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_REMARK, 8'h64, 1'b1, 1'b1, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_QUERY, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_QUERY, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_QUERY, 8'h63, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_QUERY, 8'h64, 1'b1, 1'b1, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_GLOBAL, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_GLOBAL, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_GLOBAL, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_GLOBAL, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_GLOBAL, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_GLOBAL, 8'hff, 1'b1, 1'b1, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_POP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_QUERY, 8'hff, 1'b1, 1'b1, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_REMARK, 8'h5a, 1'b1, 1'b0, 1'b0, 1'b0));
      plan.push_back(mk_row(KIND_MARK_CHANGED, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
      n_directed = plan.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send_item(plan[i].req, plan[i].fixed, plan[i].gives, plan[i].rsp);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 63;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 63;
            end
            default: begin
               idle_pct = 38;
               stall_pct = 38;
            end
         endcase
         while (n_items < n_directed + (ph + 1) * N_RANDOM / 4) send_random_op();
         req_valid <= 1'b0;
         do @(posedge clock); while (due_q.size() != 0);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items through four idle/stall mixes; checked %0d results", n_items,
               n_results);
      $display("with %0d query hits, %0d change notices and %0d field mismatches.", n_hits,
               n_notify, n_errors);
      if (n_errors == 0 && due_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
